// ===== sv/cet_pkg.sv =====
// Shared types and codes for the contiguous extent table.
package cet_pkg;

    localparam int MAX_FILES_DEF = 16;
    localparam int MAX_BLOCKS    = 256;
    localparam int DISK_W        = 9;
    localparam logic [DISK_W-1:0] DISK_RESET = 9'd256;

    typedef enum logic [1:0] {
        CMD_CREATE = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_QUERY  = 2'd2
    } cet_cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_SPACE  = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } cet_status_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [63:0] file_key;
        logic [7:0]  extent_start;
        logic [8:0]  extent_length;
        logic [7:0]  block_number;
    } cet_in_t;

    typedef struct packed {
        logic [1:0] status;
        logic       block_allocated;
    } cet_out_t;

    typedef struct packed {
        logic [63:0] key;
        logic [7:0]  first;
        logic [8:0]  size;
    } cet_entry_t;

    // Broadcast from the sequencer to every cell.
    typedef struct packed {
        logic        eval;
        logic        commit;
        cet_cmd_t    cmd;
        logic [63:0] cmp_key;
        logic [7:0]  cmp_blk;
        cet_entry_t  new_ent;
        logic        space_ok;
    } cet_ctl_t;

    // Rippled left to right along the row of cells.
    typedef struct packed {
        logic found;
        logic covered;
        logic filled;
    } cet_link_t;

endpackage

// ===== sv/cet_cell.sv =====
// One slot of the extent table: compare, ripple link and shift from the right neighbor.
module cet_cell
    import cet_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cet_ctl_t   ctl,
    input  cet_link_t  link_in,
    output cet_link_t  link_out,
    input  cet_entry_t right_ent,
    input  logic       right_valid,
    output cet_entry_t ent,
    output logic       valid
);

    cet_entry_t  ent_reg;
    logic        valid_reg;
    logic        hit_reg;
    logic        cover_reg;
    logic        hit_next;
    logic        cover_next;
    logic [9:0]  end_blk;
    logic        do_append;

    assign end_blk    = {2'b00, ent_reg.first} + {1'b0, ent_reg.size};
    assign hit_next   = valid_reg && (ent_reg.key == ctl.cmp_key);
    assign cover_next = valid_reg && (ctl.cmp_blk >= ent_reg.first)
                        && ({2'b00, ctl.cmp_blk} < end_blk);

    // first free slot: previous one filled, this one empty
    assign do_append = ctl.space_ok && !valid_reg && link_in.filled;

    assign link_out.found   = link_in.found | hit_reg;
    assign link_out.covered = link_in.covered | cover_reg;
    assign link_out.filled  = valid_reg;

    assign ent   = ent_reg;
    assign valid = valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
            cover_reg <= 1'b0;
        end
        else
        begin
            if (ctl.eval)
            begin
                hit_reg   <= hit_next;
                cover_reg <= cover_next;
            end
            if (ctl.commit)
            begin
                case (ctl.cmd)
                    CMD_CREATE:
                    begin
                        if (do_append)
                        begin
                            valid_reg <= 1'b1;
                        end
                    end
                    CMD_DELETE:
                    begin
                        // at or after the oldest match: close the gap
                        if (link_out.found)
                        begin
                            valid_reg <= right_valid;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.commit)
        begin
            case (ctl.cmd)
                CMD_CREATE:
                begin
                    if (do_append)
                    begin
                        ent_reg <= ctl.new_ent;
                    end
                end
                CMD_DELETE:
                begin
                    if (link_out.found)
                    begin
                        ent_reg <= right_ent;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

// ===== sv/contiguous_extent_table.sv =====
// Top level: command sequencer, disk size register and the row of extent cells.
//
//  channel | direction | handshake         | payload
//  in      | input     | in_valid/in_stall | in_data (cet_in_t)
//  out     | output    | out_valid/out_stall | out_data (cet_out_t)
//  cfg     | input     | cfg_write         | cfg_data (disk_blocks)
//
// At the transfer every cell registers its compare result; in S_COMMIT the
// link chain ripples and the cells shift or append.
// in_stall is high while a command is in flight; the commit waits while the
// output register holds an untaken result under out_stall.
// Reset empties the table and sets the disk size to 256 blocks.
module contiguous_extent_table
    import cet_pkg::*;
#(
    parameter int MAX_FILES = MAX_FILES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  cet_in_t           in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output cet_out_t          out_data,
    input  logic              cfg_write,
    input  logic [DISK_W-1:0] cfg_data
);

    typedef enum logic {
        S_IDLE,
        S_COMMIT
    } state_t;

    state_t            state_reg;
    logic              out_valid_reg;
    cet_out_t          out_data_reg;
    cet_cmd_t          cmd_reg;
    cet_entry_t        new_ent_reg;
    logic              space_ok_reg;
    logic [DISK_W-1:0] disk_reg;

    logic              in_xfer;
    logic              commit;
    logic [9:0]        req_end;
    logic [9:0]        limit;
    logic              space_ok;
    cet_ctl_t          ctl;
    cet_status_t       status;
    logic              alloc;

    cet_link_t  link [MAX_FILES+1];
    cet_entry_t ent_arr [MAX_FILES+1];
    logic       valid_arr [MAX_FILES+1];

    assign in_stall  = (state_reg != S_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign commit    = (state_reg == S_COMMIT) && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign req_end  = {2'b00, in_data.extent_start} + {1'b0, in_data.extent_length};
    assign limit    = ({1'b0, disk_reg} > 10'(MAX_BLOCKS)) ? 10'(MAX_BLOCKS)
                                                          : {1'b0, disk_reg};
    assign space_ok = (req_end <= limit);

    assign ctl.eval     = in_xfer;
    assign ctl.commit   = commit;
    assign ctl.cmd      = cmd_reg;
    assign ctl.cmp_key  = in_data.file_key;
    assign ctl.cmp_blk  = in_data.block_number;
    assign ctl.new_ent  = new_ent_reg;
    assign ctl.space_ok = space_ok_reg && (cmd_reg == CMD_CREATE);

    assign link[0].found   = 1'b0;
    assign link[0].covered = 1'b0;
    assign link[0].filled  = 1'b1;
    assign ent_arr[MAX_FILES]   = '0;
    assign valid_arr[MAX_FILES] = 1'b0;

    for (genvar i = 0; i < MAX_FILES; i++)
    begin : g_cell
        cet_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .link_in     (link[i]),
            .link_out    (link[i+1]),
            .right_ent   (ent_arr[i+1]),
            .right_valid (valid_arr[i+1]),
            .ent         (ent_arr[i]),
            .valid       (valid_arr[i])
        );
    end

    always_comb
    begin
        status = ST_OK;
        alloc  = 1'b0;
        case (cmd_reg)
            CMD_CREATE:
            begin
                if (!space_ok_reg)
                begin
                    status = ST_NO_SPACE;
                end
                else if (link[MAX_FILES].filled)
                begin
                    status = ST_FULL;
                end
            end
            CMD_DELETE:
            begin
                if (!link[MAX_FILES].found)
                begin
                    status = ST_NOT_FOUND;
                end
            end
            CMD_QUERY:
            begin
                alloc = link[MAX_FILES].covered;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disk_reg <= DISK_RESET;
        end
        else if (cfg_write)
        begin
            disk_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        state_reg <= S_COMMIT;
                    end
                end
                S_COMMIT:
                begin
                    if (commit)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            cmd_reg           <= cet_cmd_t'(in_data.command);
            new_ent_reg.key   <= in_data.file_key;
            new_ent_reg.first <= in_data.extent_start;
            new_ent_reg.size  <= in_data.extent_length;
            space_ok_reg      <= space_ok;
        end
        if (commit)
        begin
            out_data_reg.status          <= status;
            out_data_reg.block_allocated <= alloc;
        end
    end

endmodule
